FILE: design/amaq_pkg.sv
// Shared constants and types for the accelerometer/magnetometer attitude block.
// No dependencies; used by amaq_norm and accel_mag_attitude_quaternion.
package amaq_pkg;

  // Width of every quaternion component on the result channel.
  localparam int OUT_W = 16;

  // Component magnitudes are reduced below 2^RED_BITS before squaring.
  localparam int RED_BITS = 30;

  // One quaternion component as delivered on the output port.
  typedef logic signed [OUT_W-1:0] quat_t;

endpackage

FILE: design/amaq_norm.sv
// Pipelined vector normaliser: magnitude reduction, sum of squares,
// digit-by-digit square root and restoring division, one digit per stage.
// Depends on amaq_pkg.
module amaq_norm #(
  parameter int N  = 3,
  parameter int W  = 33,
  parameter int F  = 14,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] in_vec [N],
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic signed [F+1:0] out_vec [N],
  output logic                out_nz,
  output logic [SW-1:0]       out_side
);

  localparam int RED  = amaq_pkg::RED_BITS;
  localparam int RW   = (W > RED) ? RED : W;
  localparam int BLW  = $clog2(W + 1);
  localparam int SUMW = 2 * RW + 2;
  localparam int K    = RW + 1;
  localparam int RMW  = K + 3;
  localparam int Q    = F + 1;
  localparam int DW   = RW + F + 1;
  localparam int LAT  = 7 + K + Q;

  // Valid, sign and side-band delay lines, one entry per stage.
  logic [LAT-1:0] v_r;
  logic [SW-1:0]  side_r [LAT];
  logic [N-1:0]   neg_r  [LAT];
  logic [N-1:0]   in_neg;

  // Stage A to D registers.
  logic [W-1:0]    a_r_r  [N];
  logic [W-1:0]    b_r_r  [N];
  logic [BLW-1:0]  b_sh_r;
  logic [RW-1:0]   c_r_r  [N];
  logic [RW-1:0]   d_r_r  [N];
  logic [2*RW-1:0] d_sq_r [N];

  // Square-root stages.
  logic [SUMW-1:0] sq_rad_r  [K+1];
  logic [RMW-1:0]  sq_rem_r  [K+1];
  logic [K-1:0]    sq_root_r [K+1];
  logic [RW-1:0]   sq_r_r    [K+1][N];
  logic            sq_nz_r   [K+1];

  // Division stages.
  logic [DW-1:0]   dv_d_r   [Q+1][N];
  logic [K-1:0]    dv_rem_r [Q+1][N];
  logic [Q-1:0]    dv_q_r   [Q+1][N];
  logic [K-1:0]    dv_nrm_r [Q+1];
  logic            dv_nz_r  [Q+1];

  logic signed [F+1:0] out_vec_r [N];
  logic                out_nz_r;

  // Combinational helpers for each stage.
  logic [BLW-1:0]  sh_nxt;
  logic [SUMW-1:0] sum_nxt;
  logic [RMW-1:0]  sq_t     [K];
  logic [RMW-1:0]  sq_trial [K];
  logic [K-1:0]    sq_ge;
  logic [DW-1:0]   setup_d  [N];
  logic [K:0]      dv_t     [Q][N];
  logic            dv_ge    [Q][N];

  // Signs of the incoming components.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      in_neg[i] = in_vec[i][W-1];
    end
  end

  // Reduction shift: bring the largest magnitude below 2^RED.
  always_comb begin
    logic [W-1:0] mx;
    int           bl;
    mx = '0;
    bl = 0;
    for (int i = 0; i < N; i++) begin
      if (a_r_r[i] > mx) begin
        mx = a_r_r[i];
      end
    end
    for (int j = 0; j < W; j++) begin
      if (mx[j]) begin
        bl = j + 1;
      end
    end
    sh_nxt = (bl > RED) ? BLW'(bl - RED) : '0;
  end

  // Sum of the squared reduced magnitudes.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < N; i++) begin
      sum_nxt = sum_nxt + SUMW'(d_sq_r[i]);
    end
  end

  // One root digit per stage: bring down two radicand bits and try.
  always_comb begin
    for (int k = 0; k < K; k++) begin
      sq_t[k]     = {sq_rem_r[k][RMW-3:0], sq_rad_r[k][SUMW-1 -: 2]};
      sq_trial[k] = {1'b0, sq_root_r[k], 2'b01};
      sq_ge[k]    = (sq_t[k] >= sq_trial[k]);
    end
  end

  // Rounded dividend: r * 2^F plus half the norm.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      setup_d[i] = {1'b0, sq_r_r[K][i], {F{1'b0}}} + DW'(sq_root_r[K] >> 1);
    end
  end

  // One quotient bit per stage for every component.
  always_comb begin
    for (int j = 0; j < Q; j++) begin
      for (int i = 0; i < N; i++) begin
        dv_t[j][i]  = {dv_rem_r[j][i], dv_d_r[j][i][Q-1-j]};
        dv_ge[j][i] = (dv_t[j][i] >= {1'b0, dv_nrm_r[j]});
      end
    end
  end

  // Valid bits travel with the data; the whole pipe holds on a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  // Payload registers of every stage.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      neg_r[0]  <= in_neg;
      for (int s = 1; s < LAT; s++) begin
        side_r[s] <= side_r[s-1];
        neg_r[s]  <= neg_r[s-1];
      end

      for (int i = 0; i < N; i++) begin
        a_r_r[i]  <= in_vec[i][W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        b_r_r[i]  <= a_r_r[i];
        c_r_r[i]  <= RW'(b_r_r[i] >> b_sh_r);
        d_r_r[i]  <= c_r_r[i];
        d_sq_r[i] <= {{RW{1'b0}}, c_r_r[i]} * {{RW{1'b0}}, c_r_r[i]};
        sq_r_r[0][i] <= d_r_r[i];
      end
      b_sh_r <= sh_nxt;

      sq_rad_r[0]  <= sum_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_nz_r[0]   <= (sum_nxt != '0);
      for (int k = 0; k < K; k++) begin
        if (sq_ge[k]) begin
          sq_rem_r[k+1]  <= sq_t[k] - sq_trial[k];
          sq_root_r[k+1] <= {sq_root_r[k][K-2:0], 1'b1};
        end else begin
          sq_rem_r[k+1]  <= sq_t[k];
          sq_root_r[k+1] <= {sq_root_r[k][K-2:0], 1'b0};
        end
        sq_rad_r[k+1] <= {sq_rad_r[k][SUMW-3:0], 2'b00};
        sq_r_r[k+1]   <= sq_r_r[k];
        sq_nz_r[k+1]  <= sq_nz_r[k];
      end

      dv_nrm_r[0] <= sq_root_r[K];
      dv_nz_r[0]  <= sq_nz_r[K];
      for (int i = 0; i < N; i++) begin
        dv_d_r[0][i]   <= setup_d[i];
        dv_rem_r[0][i] <= K'(setup_d[i] >> Q);
        dv_q_r[0][i]   <= '0;
      end
      for (int j = 0; j < Q; j++) begin
        dv_nrm_r[j+1] <= dv_nrm_r[j];
        dv_nz_r[j+1]  <= dv_nz_r[j];
        for (int i = 0; i < N; i++) begin
          dv_d_r[j+1][i] <= dv_d_r[j][i];
          if (dv_ge[j][i]) begin
            dv_rem_r[j+1][i] <= K'(dv_t[j][i] - {1'b0, dv_nrm_r[j]});
            dv_q_r[j+1][i]   <= {dv_q_r[j][i][Q-2:0], 1'b1};
          end else begin
            dv_rem_r[j+1][i] <= K'(dv_t[j][i]);
            dv_q_r[j+1][i]   <= {dv_q_r[j][i][Q-2:0], 1'b0};
          end
        end
      end

      // Sign restored last; a zero vector gives zero components.
      out_nz_r <= dv_nz_r[Q];
      for (int i = 0; i < N; i++) begin
        if (!dv_nz_r[Q]) begin
          out_vec_r[i] <= '0;
        end else if (neg_r[LAT-2][i]) begin
          out_vec_r[i] <= -$signed({1'b0, dv_q_r[Q][i]});
        end else begin
          out_vec_r[i] <= $signed({1'b0, dv_q_r[Q][i]});
        end
      end
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_vec   = out_vec_r;
  assign out_nz    = out_nz_r;
  assign out_side  = side_r[LAT-1];

endmodule

FILE: design/accel_mag_attitude_quaternion.sv
// Top level: attitude quaternion from one accelerometer and one magnetometer word.
// Depends on amaq_pkg and amaq_norm.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, in_acc_*, in_mag_*   | sink
//   out     | out_valid, out_ready, out_quat_*,        | source
//           | out_degenerate                           |
//
// One word is accepted every cycle while the output side keeps up.
// A word passes the registered front end, the z and y normalisers, the x-axis stages, the x
// normaliser, the quaternion-term stage, the quaternion normaliser and the output register.
// A stall at the output freezes every stage at once; nothing is dropped or repeated.
// Reset clears the valid bits only; the pipeline then runs empty.
module accel_mag_attitude_quaternion #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_x,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_y,
  input  logic signed [SAMPLE_BITS-1:0] in_acc_z,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_x,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_y,
  input  logic signed [SAMPLE_BITS-1:0] in_mag_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output amaq_pkg::quat_t               out_quat_x,
  output amaq_pkg::quat_t               out_quat_y,
  output amaq_pkg::quat_t               out_quat_z,
  output amaq_pkg::quat_t               out_quat_w,
  output logic                          out_degenerate
);

  localparam int S   = SAMPLE_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int OW  = amaq_pkg::OUT_W;
  localparam int W1  = 2 * S + 1;
  localparam int VW  = F + 2;
  localparam int PX  = 2 * VW;
  localparam int WQ  = F + 4;
  localparam int VX  = (VW > OW + 1) ? VW : OW + 1;
  localparam int SDX = 1 + 6 * VW;

  localparam logic signed [WQ-1:0] ONE_Q   = WQ'(1 << F);
  localparam logic signed [VW-1:0] ONE_V   = VW'(1 << F);
  localparam logic signed [VX-1:0] SAT_MAX = VX'((1 << (OW - 1)) - 1);
  localparam logic signed [VX-1:0] SAT_MIN = -VX'(1 << (OW - 1));

  // Clamp one unit component to the output width.
  function automatic amaq_pkg::quat_t sat_q(input logic signed [VW-1:0] v);
    logic signed [VX-1:0] e;
    e = VX'(v);
    if (e > SAT_MAX) begin
      e = SAT_MAX;
    end else if (e < SAT_MIN) begin
      e = SAT_MIN;
    end
    return e[OW-1:0];
  endfunction

  localparam amaq_pkg::quat_t IDENT_W = sat_q(ONE_V);

  logic en;
  logic out_valid_r;

  // The whole pipeline advances unless a finished word is held at the output.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: register the samples.
  logic                s1_v_r;
  logic signed [S-1:0] s1_acc_r [3];
  logic signed [S-1:0] s1_mag_r [3];

  // Stage 2: cross-product terms of acc and mag.
  logic                  s2_v_r;
  logic signed [S-1:0]   s2_acc_r [3];
  logic signed [2*S-1:0] s2_p_r   [6];

  // Stage 3: y axis = acc x mag, acc widened to match.
  logic                 s3_v_r;
  logic signed [W1-1:0] s3_acc_r [3];
  logic signed [W1-1:0] s3_yr_r  [3];

  // Normalised z (acc) and y axes.
  logic                 ny_valid;
  logic signed [VW-1:0] za [3];
  logic signed [VW-1:0] yu [3];
  logic                 za_nz;
  logic                 yu_nz;
  logic                 y_side;

  // Stage 4: cross-product terms of y and z.
  logic                 s4_v_r;
  logic                 s4_ok_r;
  logic signed [VW-1:0] s4_yu_r [3];
  logic signed [VW-1:0] s4_za_r [3];
  logic signed [PX-1:0] s4_p_r  [6];

  // Stage 5: x axis = y x z.
  logic                 s5_v_r;
  logic [SDX-1:0]       s5_side_r;
  logic signed [PX-1:0] s5_xr_r [3];

  // Normalised x axis, with y and z carried alongside.
  logic                 nx_valid;
  logic signed [VW-1:0] xu [3];
  logic                 xu_nz;
  logic [SDX-1:0]       x_side;
  logic signed [VW-1:0] xs_yu [3];
  logic signed [VW-1:0] xs_za [3];
  logic                 xs_ok;
  logic signed [WQ-1:0] w_sum;

  // Stage 6: unscaled quaternion terms.
  logic                 s6_v_r;
  logic                 s6_ok_r;
  logic signed [WQ-1:0] s6_qr_r [4];

  // Normalised quaternion.
  logic                 nq_valid;
  logic signed [VW-1:0] qu [4];
  logic                 q_ok;

  amaq_pkg::quat_t out_qx_r;
  amaq_pkg::quat_t out_qy_r;
  amaq_pkg::quat_t out_qz_r;
  amaq_pkg::quat_t out_qw_r;
  logic            out_deg_r;

  // Valid bits of the top-level stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= ny_valid;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= nx_valid;
      out_valid_r <= nq_valid;
    end
  end

  // Front end: samples, cross-product terms and the raw y axis.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_acc_r[0] <= in_acc_x;
      s1_acc_r[1] <= in_acc_y;
      s1_acc_r[2] <= in_acc_z;
      s1_mag_r[0] <= in_mag_x;
      s1_mag_r[1] <= in_mag_y;
      s1_mag_r[2] <= in_mag_z;

      s2_acc_r  <= s1_acc_r;
      s2_p_r[0] <= s1_acc_r[1] * s1_mag_r[2];
      s2_p_r[1] <= s1_acc_r[2] * s1_mag_r[1];
      s2_p_r[2] <= s1_acc_r[2] * s1_mag_r[0];
      s2_p_r[3] <= s1_acc_r[0] * s1_mag_r[2];
      s2_p_r[4] <= s1_acc_r[0] * s1_mag_r[1];
      s2_p_r[5] <= s1_acc_r[1] * s1_mag_r[0];

      for (int i = 0; i < 3; i++) begin
        s3_acc_r[i] <= W1'(s2_acc_r[i]);
        s3_yr_r[i]  <= W1'(s2_p_r[2*i]) - W1'(s2_p_r[2*i+1]);
      end
    end
  end

  amaq_norm #(.N(3), .W(W1), .F(F), .SW(1)) u_norm_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_vec    (s3_acc_r),
    .in_side   (1'b0),
    .out_valid (),
    .out_vec   (za),
    .out_nz    (za_nz),
    .out_side  ()
  );

  amaq_norm #(.N(3), .W(W1), .F(F), .SW(1)) u_norm_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_vec    (s3_yr_r),
    .in_side   (1'b0),
    .out_valid (ny_valid),
    .out_vec   (yu),
    .out_nz    (yu_nz),
    .out_side  (y_side)
  );

  // Middle: raw x axis from the unit y and z axes.
  always_ff @(posedge clk) begin
    if (en) begin
      s4_ok_r   <= za_nz && yu_nz && !y_side;
      s4_yu_r   <= yu;
      s4_za_r   <= za;
      s4_p_r[0] <= yu[1] * za[2];
      s4_p_r[1] <= yu[2] * za[1];
      s4_p_r[2] <= yu[2] * za[0];
      s4_p_r[3] <= yu[0] * za[2];
      s4_p_r[4] <= yu[0] * za[1];
      s4_p_r[5] <= yu[1] * za[0];

      for (int i = 0; i < 3; i++) begin
        s5_xr_r[i] <= s4_p_r[2*i] - s4_p_r[2*i+1];
      end
      s5_side_r <= {s4_ok_r, s4_yu_r[0], s4_yu_r[1], s4_yu_r[2],
                    s4_za_r[0], s4_za_r[1], s4_za_r[2]};
    end
  end

  amaq_norm #(.N(3), .W(PX), .F(F), .SW(SDX)) u_norm_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_v_r),
    .in_vec    (s5_xr_r),
    .in_side   (s5_side_r),
    .out_valid (nx_valid),
    .out_vec   (xu),
    .out_nz    (xu_nz),
    .out_side  (x_side)
  );

  // Unpack the carried axes and form the trace term.
  assign xs_ok    = x_side[SDX-1];
  assign xs_yu[0] = x_side[6*VW-1 -: VW];
  assign xs_yu[1] = x_side[5*VW-1 -: VW];
  assign xs_yu[2] = x_side[4*VW-1 -: VW];
  assign xs_za[0] = x_side[3*VW-1 -: VW];
  assign xs_za[1] = x_side[2*VW-1 -: VW];
  assign xs_za[2] = x_side[VW-1 -: VW];
  assign w_sum    = ONE_Q + WQ'(xu[0]) + WQ'(xs_yu[1]) + WQ'(xs_za[2]);

  // Quaternion terms before scaling; degenerate frames are flagged here.
  always_ff @(posedge clk) begin
    if (en) begin
      s6_ok_r    <= xs_ok && xu_nz && (w_sum > 0);
      s6_qr_r[0] <= WQ'(xs_za[1]) - WQ'(xs_yu[2]);
      s6_qr_r[1] <= WQ'(xu[2]) - WQ'(xs_za[0]);
      s6_qr_r[2] <= WQ'(xs_yu[0]) - WQ'(xu[1]);
      s6_qr_r[3] <= w_sum;
    end
  end

  amaq_norm #(.N(4), .W(WQ), .F(F), .SW(1)) u_norm_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s6_v_r),
    .in_vec    (s6_qr_r),
    .in_side   (s6_ok_r),
    .out_valid (nq_valid),
    .out_vec   (qu),
    .out_nz    (),
    .out_side  (q_ok)
  );

  // Output register: clamp, or the identity for a degenerate frame.
  always_ff @(posedge clk) begin
    if (en) begin
      out_deg_r <= !q_ok;
      if (q_ok) begin
        out_qx_r <= sat_q(qu[0]);
        out_qy_r <= sat_q(qu[1]);
        out_qz_r <= sat_q(qu[2]);
        out_qw_r <= sat_q(qu[3]);
      end else begin
        out_qx_r <= '0;
        out_qy_r <= '0;
        out_qz_r <= '0;
        out_qw_r <= IDENT_W;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quat_x     = out_qx_r;
  assign out_quat_y     = out_qy_r;
  assign out_quat_z     = out_qz_r;
  assign out_quat_w     = out_qw_r;
  assign out_degenerate = out_deg_r;

  // A degenerate frame always leaves as the identity quaternion.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0 && out_quat_w == IDENT_W)
    else $error("degenerate word is not the identity quaternion");

  // A held output word must stop the intake.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the output is stalled");

  // The output w component and degenerate flag change only after the word has been taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_quat_w) && $stable(out_degenerate))
    else $error("stalled output word changed");

endmodule
